@@ sv/dda_pkg.sv @@
package dda_pkg;

  localparam int COORD_W = 6;
  localparam int FRAC_W = 16;
  // dividend is |dmin| << FRAC_W
  localparam int DIVD_W = COORD_W + FRAC_W;
  // signed accumulator / slope: integer part, fraction, sign and headroom
  localparam int ACC_W = DIVD_W + 2;
  localparam int DCNT_W = 5;
  localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(DIVD_W);

  typedef logic [1:0] step_t;

  // jump taken when the condition holds, else fall through to step + 1
  typedef enum logic [2:0] {
    C_NO_REQ   = 3'b001,
    C_ZERO_LEN = 3'b010,
    C_DIV_BUSY = 3'b100
  } cond_t;

  // walk step reuses C_NO_REQ (stay until walk_done); it alone wraps the program
  typedef struct packed {
    logic  in_rdy;
    logic  div_init;
    logic  div_step;
    logic  emit;
    cond_t cond;
    step_t target;
  } ctrl_t;

  localparam step_t S_WAIT = 2'd0;
  localparam step_t S_DINIT = 2'd1;
  localparam step_t S_DSTEP = 2'd2;
  localparam step_t S_EMIT = 2'd3;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c = '{in_rdy: 1'b0, div_init: 1'b0, div_step: 1'b0, emit: 1'b0,
          cond: C_NO_REQ, target: S_WAIT};
    unique case (s)
      S_WAIT: begin
        c.in_rdy = 1'b1;
        c.cond = C_NO_REQ;
        c.target = S_WAIT;
      end
      S_DINIT: begin
        c.div_init = 1'b1;
        c.cond = C_ZERO_LEN;
        c.target = S_EMIT;
      end
      S_DSTEP: begin
        c.div_step = 1'b1;
        c.cond = C_DIV_BUSY;
        c.target = S_DSTEP;
      end
      S_EMIT: begin
        c.emit = 1'b1;
        c.cond = C_NO_REQ;
        c.target = S_EMIT;
      end
      default: c.cond = C_NO_REQ;
    endcase
    return c;
  endfunction

endpackage

@@ sv/dda_line_rasterizer.sv @@
// DDA line rasterizer.
// Input channel (in_valid/in_ready): one request carries a segment as two
// 6-bit grid endpoints (x_start, y_start) and (x_end, y_end).
// Output channel (out_valid/out_ready): one request per marked cell,
// point_x/point_y, with last_point high on the final cell of the segment.
// Control is a four-step microprogram (wait, divider init, divide, walk)
// held in a constant table; one control word per step drives the datapath.
// The slope is a restoring division, one quotient bit per cycle, giving
// a 22-bit quotient. out_valid rises after the divider init and divide
// steps (a zero-length segment skips the division and goes from init
// straight to the walk). The walk then gives one cell per cycle while
// out_ready is high; in_ready is high only in the wait step, so segments
// are handled one at a time.
// When the receiver stalls, the walk holds and the current cell stays on
// the output unchanged until it is taken.
// Reset returns the sequencer to the wait step; no other state needs clearing.
module dda_line_rasterizer #(
  parameter int GRID_SIDE = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [5:0] x_start,
  input  logic [5:0] y_start,
  input  logic [5:0] x_end,
  input  logic [5:0] y_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] point_x,
  output logic [5:0] point_y,
  output logic       last_point
);

  localparam int CW = dda_pkg::COORD_W;
  localparam int DW = dda_pkg::DIVD_W;
  localparam int AW = dda_pkg::ACC_W;
  localparam int FW = dda_pkg::FRAC_W;
  localparam int KW = $clog2(GRID_SIDE + 1);

  // sequencer
  dda_pkg::step_t step, step_next;
  dda_pkg::ctrl_t cw;
  logic cond_hit;

  // datapath registers
  logic                        x_major;
  logic                        neg;
  logic [CW-1:0]               m;
  logic [CW-1:0]               maj_end;
  logic [CW-1:0]               span;
  logic signed [AW-1:0]        acc;
  logic [DW-1:0]               quo;
  logic [CW:0]                 rem;
  logic [dda_pkg::DCNT_W-1:0]  div_cnt;
  logic [KW-1:0]               k;

  // input decode
  logic signed [CW:0] dx, dy;
  logic [CW-1:0] adx, ady;
  logic          xm_in;
  logic [CW-1:0] maj0, maj1, min0, min1;
  logic [CW-1:0] s_maj0, s_maj1, s_min0, s_min1;
  logic signed [CW:0] dmin;
  logic [CW-1:0] dmag;

  // divider step
  logic [CW:0] rem_sh;
  logic        q_bit;

  logic signed [AW-1:0] slope;
  logic                 last;
  logic                 out_acc;
  logic                 walk_done;
  logic [CW-1:0]        minor;

  assign cw = dda_pkg::ucode(step);

  always_comb begin
    dx = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
    dy = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
    adx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    ady = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    xm_in = adx > ady;
    maj0 = xm_in ? x_start : y_start;
    maj1 = xm_in ? x_end : y_end;
    min0 = xm_in ? y_start : x_start;
    min1 = xm_in ? y_end : x_end;
    // walk upward along the major axis
    if (maj0 > maj1) begin
      s_maj0 = maj1;
      s_maj1 = maj0;
      s_min0 = min1;
      s_min1 = min0;
    end else begin
      s_maj0 = maj0;
      s_maj1 = maj1;
      s_min0 = min0;
      s_min1 = min1;
    end
    dmin = $signed({1'b0, s_min1}) - $signed({1'b0, s_min0});
    dmag = dmin[CW] ? CW'(-dmin) : dmin[CW-1:0];
  end

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem[CW-1:0], quo[DW-1]};
  assign q_bit = rem_sh >= {1'b0, span};

  // quotient magnitude never exceeds 1.0 in Q.16, so it fits the accumulator
  assign slope = neg ? -$signed(AW'(quo)) : $signed(AW'(quo));

  assign last = (m == maj_end) || (k == KW'(GRID_SIDE - 1));
  assign out_acc = cw.emit && out_ready;
  assign walk_done = out_acc && last;

  // accumulator never drops below the end value, so it stays non-negative
  assign minor = acc[AW-1] ? '0 : acc[FW+CW-1:FW];

  always_comb begin
    unique case (cw.cond)
      dda_pkg::C_NO_REQ:   cond_hit = cw.emit ? !walk_done : !in_valid;
      dda_pkg::C_ZERO_LEN: cond_hit = span == '0;
      dda_pkg::C_DIV_BUSY: cond_hit = div_cnt != dda_pkg::DCNT_W'(1);
      default:             cond_hit = 1'b0;
    endcase
    // fall-through from the walk step wraps back to the wait step
    step_next = cond_hit ? cw.target : step + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= dda_pkg::S_WAIT;
    end else begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.in_rdy && in_valid) begin
      x_major <= xm_in;
      m <= s_maj0;
      maj_end <= s_maj1;
      span <= s_maj1 - s_maj0;
      neg <= dmin[CW];
      acc <= $signed(AW'({s_min0, FW'(0)}));
      quo <= {dmag, FW'(0)};
      k <= '0;
    end
    if (cw.div_init) begin
      rem <= '0;
      div_cnt <= dda_pkg::DIV_STEPS;
    end
    if (cw.div_step) begin
      rem <= q_bit ? rem_sh - {1'b0, span} : rem_sh;
      quo <= {quo[DW-2:0], q_bit};
      div_cnt <= div_cnt - dda_pkg::DCNT_W'(1);
    end
    if (out_acc) begin
      m <= m + CW'(1);
      acc <= acc + slope;
      k <= k + KW'(1);
    end
  end

  assign in_ready = cw.in_rdy;
  assign out_valid = cw.emit;
  assign point_x = x_major ? m : minor;
  assign point_y = x_major ? minor : m;
  assign last_point = last;

endmodule
